### design/tha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tha_pkg;

    // Number of CORDIC micro-rotations and the size of the arctangent table
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_ITER      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int IDX_W         = $clog2(TABLE_LEN);

    // Coordinate and angle widths
    localparam int ACCEL_W     = 16;
    localparam int COORD_SHIFT = 24;
    localparam int CW          = ACCEL_W + 1 + COORD_SHIFT + 2;
    localparam int ZW          = 27;
    localparam int THR_W       = 15;
    localparam int SQ_W        = 31;
    localparam int THR2_W      = 30;
    localparam int HUE_W       = 9;
    localparam int FRAC_W      = 16;

    // Angles in 1/65536 degree
    localparam logic signed [ZW-1:0] DEG_0   = '0;
    localparam logic signed [ZW-1:0] DEG_90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] DEG_180 = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] DEG_270 = ZW'(270 * 65536);
    localparam logic signed [ZW-1:0] DEG_360 = ZW'(360 * 65536);

    localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(359);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2458);

    // One item as it travels down the rotation pipeline
    typedef struct packed {
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
        logic signed [ZW-1:0] z;
        logic                 bypass;
        logic                 dead;
    } stage_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_tab(input logic [IDX_W-1:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = ZW'(2949120);
            5'd1:    r = ZW'(1740967);
            5'd2:    r = ZW'(919879);
            5'd3:    r = ZW'(466945);
            5'd4:    r = ZW'(234379);
            5'd5:    r = ZW'(117304);
            5'd6:    r = ZW'(58666);
            5'd7:    r = ZW'(29335);
            5'd8:    r = ZW'(14668);
            5'd9:    r = ZW'(7334);
            5'd10:   r = ZW'(3667);
            5'd11:   r = ZW'(1833);
            5'd12:   r = ZW'(917);
            5'd13:   r = ZW'(458);
            5'd14:   r = ZW'(229);
            5'd15:   r = ZW'(115);
            5'd16:   r = ZW'(57);
            5'd17:   r = ZW'(29);
            5'd18:   r = ZW'(14);
            5'd19:   r = ZW'(7);
            5'd20:   r = ZW'(4);
            5'd21:   r = ZW'(2);
            5'd22:   r = ZW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### design/tha_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module tha_cordic_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [tha_pkg::IDX_W-1:0]     stage_idx,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire tha_pkg::stage_t               in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output tha_pkg::stage_t                    out_data
);

    logic            valid_reg;
    tha_pkg::stage_t data_reg;
    tha_pkg::stage_t data_next;
    logic signed [tha_pkg::CW-1:0] du;
    logic signed [tha_pkg::CW-1:0] dv;

    // Take a new transaction when empty or when the downstream side drains
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // One vectoring micro-rotation; hold axis and zero cases unchanged
    always_comb begin
        du        = in_data.v >>> stage_idx;
        dv        = in_data.u >>> stage_idx;
        data_next = in_data;
        if (!in_data.bypass) begin
            if (!in_data.v[tha_pkg::CW-1]) begin
                data_next.u = in_data.u + du;
                data_next.v = in_data.v - dv;
                data_next.z = in_data.z + tha_pkg::atan_tab(stage_idx);
            end else begin
                data_next.u = in_data.u - du;
                data_next.v = in_data.v + dv;
                data_next.z = in_data.z - tha_pkg::atan_tab(stage_idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### design/tilt_to_hue_angle_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one pair per cycle unless the output stalls; each CORDIC micro-rotation
// owns one register stage, preceded by a squaring stage and a compare/prepare stage and
// followed by a wrap stage.
// Reset (aresetn low, synchronous) clears all stage valid bits and sets the
// dead-zone threshold to 2458.
module tilt_to_hue_angle_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [15:0]            s_accel_x,
    input  wire logic signed [15:0]            s_accel_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [8:0]                         m_hue_degrees,
    output logic                               m_tilted,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [14:0]                   cfg_data
);

    // Configuration register
    logic [tha_pkg::THR_W-1:0] thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tha_pkg::THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // Ready chain from the output back to the input
    logic ready_a;
    logic ready_b;
    logic ready_out;
    logic                  valid_w [0:tha_pkg::NUM_ITER];
    logic                  ready_w [0:tha_pkg::NUM_ITER];
    tha_pkg::stage_t       data_w  [0:tha_pkg::NUM_ITER];

    // Stage A: square the inputs and the threshold
    logic                              a_valid_reg;
    logic signed [15:0]                a_x_reg;
    logic signed [15:0]                a_y_reg;
    logic [tha_pkg::SQ_W-1:0]          a_sqx_reg;
    logic [tha_pkg::SQ_W-1:0]          a_sqy_reg;
    logic [tha_pkg::THR2_W-1:0]        a_thr2_reg;
    logic signed [31:0]                sqx_full;
    logic signed [31:0]                sqy_full;
    logic [31:0]                       thr2_full;

    assign ready_a  = !a_valid_reg || ready_b;
    assign s_ready  = ready_a;
    assign sqx_full = s_accel_x * s_accel_x;
    assign sqy_full = s_accel_y * s_accel_y;
    assign thr2_full = {17'd0, thr_reg} * {17'd0, thr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ready_a) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && s_valid) begin
            a_x_reg    <= s_accel_x;
            a_y_reg    <= s_accel_y;
            a_sqx_reg  <= sqx_full[tha_pkg::SQ_W-1:0];
            a_sqy_reg  <= sqy_full[tha_pkg::SQ_W-1:0];
            a_thr2_reg <= thr2_full[tha_pkg::THR2_W-1:0];
        end
    end

    // Stage B: dead-zone compare, axis detection and half-plane fold
    logic              b_valid_reg;
    tha_pkg::stage_t   b_data_reg;
    tha_pkg::stage_t   b_data_next;
    logic [tha_pkg::SQ_W:0]     mag2;
    logic signed [16:0]         u_fold;
    logic signed [16:0]         v_fold;

    assign ready_b = !b_valid_reg || ready_w[0];

    always_comb begin
        mag2 = {1'b0, a_sqx_reg} + {1'b0, a_sqy_reg};
        // Rotate (-x, -y); when x > 0 negate into the right half plane and start at 180
        if (!a_x_reg[15] && (a_x_reg != 16'sd0)) begin
            u_fold        = {a_x_reg[15], a_x_reg};
            v_fold        = {a_y_reg[15], a_y_reg};
            b_data_next.z = tha_pkg::DEG_180;
        end else begin
            u_fold        = -{a_x_reg[15], a_x_reg};
            v_fold        = -{a_y_reg[15], a_y_reg};
            b_data_next.z = tha_pkg::DEG_0;
        end
        b_data_next.u      = tha_pkg::CW'({u_fold, {tha_pkg::COORD_SHIFT{1'b0}}});
        b_data_next.v      = tha_pkg::CW'({v_fold, {tha_pkg::COORD_SHIFT{1'b0}}});
        b_data_next.u      = {{2{u_fold[16]}}, u_fold, {tha_pkg::COORD_SHIFT{1'b0}}};
        b_data_next.v      = {{2{v_fold[16]}}, v_fold, {tha_pkg::COORD_SHIFT{1'b0}}};
        b_data_next.dead   = mag2 < {2'd0, a_thr2_reg};
        b_data_next.bypass = (a_x_reg == 16'sd0) || (a_y_reg == 16'sd0);
        // Exact angle on an axis; the zero vector gives 180
        if (a_y_reg == 16'sd0) begin
            b_data_next.z = a_x_reg[15] ? tha_pkg::DEG_0 : tha_pkg::DEG_180;
        end else if (a_x_reg == 16'sd0) begin
            b_data_next.z = a_y_reg[15] ? tha_pkg::DEG_90 : tha_pkg::DEG_270;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ready_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_b && a_valid_reg) begin
            b_data_reg <= b_data_next;
        end
    end

    // CORDIC rotation pipeline
    assign valid_w[0] = b_valid_reg;
    assign data_w[0]  = b_data_reg;
    assign ready_w[tha_pkg::NUM_ITER] = ready_out;

    for (genvar k = 0; k < tha_pkg::NUM_ITER; k++) begin : g_rot
        tha_cordic_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (tha_pkg::IDX_W'(k)),
            .in_valid  (valid_w[k]),
            .in_ready  (ready_w[k]),
            .in_data   (data_w[k]),
            .out_valid (valid_w[k+1]),
            .out_ready (ready_w[k+1]),
            .out_data  (data_w[k+1])
        );
    end

    // Output stage: wrap into one turn, truncate to whole degrees, clamp; dead-zone items give zero
    logic                         m_valid_reg;
    logic [tha_pkg::HUE_W-1:0]    hue_reg;
    logic [tha_pkg::HUE_W-1:0]    hue_next;
    logic                         tilted_reg;
    logic signed [tha_pkg::ZW-1:0] z_wrap;
    logic [tha_pkg::ZW-tha_pkg::FRAC_W-1:0] hue_whole;

    assign ready_out = !m_valid_reg || m_ready;

    always_comb begin
        z_wrap = data_w[tha_pkg::NUM_ITER].z;
        if (data_w[tha_pkg::NUM_ITER].z < 0) begin
            z_wrap = data_w[tha_pkg::NUM_ITER].z + tha_pkg::DEG_360;
        end else if (data_w[tha_pkg::NUM_ITER].z >= tha_pkg::DEG_360) begin
            z_wrap = data_w[tha_pkg::NUM_ITER].z - tha_pkg::DEG_360;
        end
        hue_whole = z_wrap[tha_pkg::ZW-1:tha_pkg::FRAC_W];
        if (data_w[tha_pkg::NUM_ITER].dead) begin
            hue_next = '0;
        end else if (hue_whole > {2'd0, tha_pkg::HUE_MAX}) begin
            hue_next = tha_pkg::HUE_MAX;
        end else begin
            hue_next = hue_whole[tha_pkg::HUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ready_out) begin
            m_valid_reg <= valid_w[tha_pkg::NUM_ITER];
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out && valid_w[tha_pkg::NUM_ITER]) begin
            hue_reg    <= hue_next;
            tilted_reg <= !data_w[tha_pkg::NUM_ITER].dead;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hue_degrees = hue_reg;
    assign m_tilted      = tilted_reg;

    // Dead-zone results carry hue zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_tilted) |-> (m_hue_degrees == 9'd0))
        else $error("dead-zone result with nonzero hue");

    // Hue always stays inside one turn
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hue_degrees <= tha_pkg::HUE_MAX))
        else $error("hue out of range");

    // Input back-pressure only when stages A and B are full and the output holds a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && a_valid_reg && b_valid_reg))
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire

### verif/tilt_to_hue_angle_core_tb.sv
`timescale 1ns / 1ps

module tilt_to_hue_angle_core_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 3 + tha_pkg::NUM_ITER + 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int BLOCK_ITEMS  = 67;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_DIRECTED = 25;

    // Angles in 1/65536 degree
    localparam longint ANG_90  = 64'sd90 * 64'sd65536;
    localparam longint ANG_180 = 64'sd180 * 64'sd65536;
    localparam longint ANG_270 = 64'sd270 * 64'sd65536;
    localparam longint ANG_360 = 64'sd360 * 64'sd65536;
    localparam longint HUE_LAST = 359;

    // atan(2^-i) in 1/65536 degree
    localparam longint ATAN_STEP [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [tha_pkg::HUE_W-1:0] hue;
        logic                      tilted;
    } hue_result_t;

    typedef struct {
        int          thr;
        int          x;
        int          y;
        bit          typed;
        int          hue;
        int          tilted;
    } pair_case_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [tha_pkg::ACCEL_W-1:0] s_accel_x;
    logic signed [tha_pkg::ACCEL_W-1:0] s_accel_y;
    logic                              m_valid;
    logic                              m_ready;
    logic [tha_pkg::HUE_W-1:0]         m_hue_degrees;
    logic                              m_tilted;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [tha_pkg::THR_W-1:0]         cfg_data;

    hue_result_t                 expected_hues[$];
    logic [tha_pkg::THR_W-1:0]   dead_zone_thr = tha_pkg::THR_RESET;
    int                          error_count = 0;
    int                          cycle_count = 0;
    int                          sender_idle_pct = 0;
    int                          receiver_idle_pct = 0;
    int                          hold_requests = 0;

    // Directed pairs: dead zone edges, axes, extremes, wrap around zero and 180 degrees
    pair_case_t directed_cases [NUM_DIRECTED] = '{
        '{2458, 0, 0, 1, 0, 0},
        '{2458, 2457, 0, 1, 0, 0},
        '{2458, 1738, 1738, 0, 0, 0},
        '{2458, 2458, 0, 1, 180, 1},
        '{2458, -2458, 0, 1, 0, 1},
        '{2458, 0, 2458, 1, 270, 1},
        '{2458, 0, -2458, 1, 90, 1},
        '{2458, 32767, 0, 1, 180, 1},
        '{2458, -32768, 0, 1, 0, 1},
        '{2458, 0, 32767, 1, 270, 1},
        '{2458, 0, -32768, 1, 90, 1},
        '{2458, 32767, 32767, 0, 0, 0},
        '{2458, -32768, -32768, 0, 0, 0},
        '{2458, -32768, 32767, 0, 0, 0},
        '{2458, 32767, -32768, 0, 0, 0},
        '{2458, -32768, -1, 0, 0, 0},
        '{2458, -32768, 1, 0, 0, 0},
        '{2458, 32767, 1, 0, 0, 0},
        '{2458, 32767, -1, 0, 0, 0},
        '{0, 0, 0, 1, 180, 1},
        '{0, -1, 0, 1, 0, 1},
        '{0, 1, -1, 0, 0, 0},
        '{32767, 32767, 0, 1, 180, 1},
        '{32767, 32766, 0, 1, 0, 0},
        '{32767, -32768, -32768, 0, 0, 0}
    };

    tilt_to_hue_angle_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_accel_x     (s_accel_x),
        .s_accel_y     (s_accel_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hue_degrees (m_hue_degrees),
        .m_tilted      (m_tilted),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Hue of one tilt pair: dead zone test on squares, then vectoring CORDIC on (-x, -y)
    function automatic hue_result_t predict_hue(input logic signed [15:0] ax,
                                                input logic signed [15:0] ay,
                                                input logic [14:0] thr);
        hue_result_t res;
        longint      x;
        longint      y;
        longint      u;
        longint      v;
        longint      z;
        longint      du;
        longint      dv;
        longint      deg;
        x = ax;
        y = ay;
        res.tilted = 1'b1;
        if (x * x + y * y < longint'(thr) * longint'(thr)) begin
            res.hue    = '0;
            res.tilted = 1'b0;
            return res;
        end
        if (x == 0 && y == 0) begin
            res.hue = 9'd180;
            return res;
        end
        u = -x;
        v = -y;
        if (v == 0) begin
            z = (u > 0) ? 64'sd0 : ANG_180;
        end else if (u == 0) begin
            z = (v > 0) ? ANG_90 : ANG_270;
        end else begin
            z = 0;
            // fold the left half plane onto the right one
            if (u < 0) begin
                u = -u;
                v = -v;
                z = ANG_180;
            end
            u = u <<< tha_pkg::COORD_SHIFT;
            v = v <<< tha_pkg::COORD_SHIFT;
            for (int i = 0; i < tha_pkg::NUM_ITER; i++) begin
                du = v >>> i;
                dv = u >>> i;
                if (v >= 0) begin
                    u += du;
                    v -= dv;
                    z += ATAN_STEP[i];
                end else begin
                    u -= du;
                    v += dv;
                    z -= ATAN_STEP[i];
                end
            end
            if (z < 0) z += ANG_360;
            if (z >= ANG_360) z -= ANG_360;
        end
        deg = z >>> 16;
        if (deg > HUE_LAST) deg = HUE_LAST;
        res.hue = deg[tha_pkg::HUE_W-1:0];
        return res;
    endfunction

    // Offer one pair, idling at random first; return at the accepting edge
    task automatic offer_pair(input logic signed [15:0] ax, input logic signed [15:0] ay);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_accel_x = ax;
        s_accel_y = ay;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every pending hue has come out
    task automatic stop_and_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_hues.size() != 0) @(posedge aclk);
    endtask

    // Write the dead-zone threshold while the pipeline is empty
    task automatic write_threshold(input logic [14:0] thr);
        stop_and_drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = thr;
        do @(posedge aclk); while (!cfg_ready);
        dead_zone_thr = thr;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int served;
        served  = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (served != hold_requests) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                served++;
            end else begin
                m_ready = ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // Check each result transaction against the oldest pending hue
    always @(posedge aclk) begin : check_results
        hue_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hues.size() == 0) begin
                $error("result with nothing pending: hue %0d tilted %0d",
                       m_hue_degrees, m_tilted);
                error_count++;
            end else begin
                want = expected_hues.pop_front();
                if (m_hue_degrees !== want.hue) begin
                    $error("hue_degrees: expected %0d, actual %0d", want.hue, m_hue_degrees);
                    error_count++;
                end
                if (m_tilted !== want.tilted) begin
                    $error("tilted: expected %0d, actual %0d", want.tilted, m_tilted);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus
    initial begin
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] big;
        logic signed [15:0] tiny;
        logic [14:0]        thr;
        hue_result_t        typed_hue;
        int                 lim;
        int                 tmp;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_accel_x = '0;
        s_accel_y = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table; rewrite the threshold when a row asks for another one
        foreach (directed_cases[k]) begin
            if (15'(directed_cases[k].thr) != dead_zone_thr)
                write_threshold(15'(directed_cases[k].thr));
            ax = 16'(directed_cases[k].x);
            ay = 16'(directed_cases[k].y);
            offer_pair(ax, ay);
            if (directed_cases[k].typed) begin
                typed_hue.hue    = 9'(directed_cases[k].hue);
                typed_hue.tilted = 1'(directed_cases[k].tilted);
                expected_hues.push_back(typed_hue);
            end else begin
                expected_hues.push_back(predict_hue(ax, ay, dead_zone_thr));
            end
        end

        // Random phases: receiver-heavy idling, sender-heavy idling, then none
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 38;
                    receiver_idle_pct = 62;
                end
                1: begin
                    sender_idle_pct   = 62;
                    receiver_idle_pct = 38;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                case (blk)
                    0: thr = 15'($urandom_range(0, 32767));
                    1: thr = '0;
                    2: thr = 15'($urandom_range(0, 4095));
                    default: thr = 15'h7FFF;
                endcase
                write_threshold(thr);
                // fill the pipeline against a stalled receiver
                if (phase == 2 && blk == 0) hold_requests++;
                repeat (BLOCK_ITEMS) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: begin
                            ax = 16'($urandom);
                            ay = 16'($urandom);
                        end
                        3, 4: begin
                            // hover around the dead-zone edge
                            lim = int'(dead_zone_thr) + int'(dead_zone_thr) / 2 + 2;
                            if (lim > 32767) lim = 32767;
                            tmp = int'($urandom_range(0, 2 * lim)) - lim;
                            ax  = 16'(tmp);
                            tmp = int'($urandom_range(0, 2 * lim)) - lim;
                            ay  = 16'(tmp);
                        end
                        5: begin
                            case ($urandom_range(0, 2))
                                0: big = -16'sd32768;
                                1: big = 16'sd32767;
                                default: big = 16'($urandom);
                            endcase
                            if ($urandom_range(0, 1)) begin
                                ax = big;
                                ay = '0;
                            end else begin
                                ax = '0;
                                ay = big;
                            end
                        end
                        6: begin
                            // just off an axis, where the angle wraps or sits near 180
                            big  = 16'($urandom);
                            tmp  = int'($urandom_range(0, 6)) - 3;
                            tiny = 16'(tmp);
                            if ($urandom_range(0, 1)) begin
                                ax = big;
                                ay = tiny;
                            end else begin
                                ax = tiny;
                                ay = big;
                            end
                        end
                        default: begin
                            ax = 16'($urandom);
                            ay = 16'($urandom);
                            ax = ax >>> $urandom_range(0, 15);
                            ay = ay >>> $urandom_range(0, 15);
                        end
                    endcase
                    offer_pair(ax, ay);
                    expected_hues.push_back(predict_hue(ax, ay, dead_zone_thr));
                end
            end
        end

        stop_and_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
